@@ hw/rtl/saa_pkg.sv @@
// Shared types and constants for the segment angle side averager.
// Holds the request payload structs, register indexes, the controller state
// type and the arctangent step table. Depends on nothing.
`timescale 1ns / 1ps

package saa_pkg;

	// Field widths of the request payloads and the configuration port.
	localparam int X_W       = 11;
	localparam int Y_W       = 10;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 2;
	localparam int TALLY_W   = 11;
	localparam int WHOLE_W   = 18;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_X_LIMIT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_X_LIMIT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SIDE_LINES = 2'd2;

	localparam logic [CFG_W-1:0] LEFT_X_LIMIT_RST   = 11'd445;
	localparam logic [CFG_W-1:0] RIGHT_X_LIMIT_RST  = 11'd355;
	localparam logic [CFG_W-1:0] MIN_SIDE_LINES_RST = 11'd7;

	// Upper clamps of the three averages.
	localparam int LEFT_ANGLE_MAX = 90;
	localparam int SIDE_ANGLE_MAX = 180;

	// Vectoring arctangent unit.
	localparam int CORDIC_STEPS = 20;
	localparam int STEP_W       = 5;
	localparam int TAB_FRAC     = 24;
	localparam int PRE_SCALE    = 16;
	localparam int CORD_W       = 31;
	localparam int Z_W          = 34;

	typedef logic signed [Z_W-1:0] z_t;

	// Serial divider.
	localparam int DIV_N     = 18;
	localparam int DIV_D     = 12;
	localparam int DIV_CNT_W = 5;

	typedef struct packed {
		logic [X_W-1:0] start_x;
		logic [Y_W-1:0] start_y;
		logic [X_W-1:0] end_x;
		logic [Y_W-1:0] end_y;
		logic           last_segment;
	} seg_t;

	typedef struct packed {
		logic [7:0]         overall_angle;
		logic [6:0]         left_angle;
		logic [7:0]         right_angle;
		logic [TALLY_W-1:0] left_kept;
		logic [TALLY_W-1:0] right_kept;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ANGLE,
		ST_SETTLE,
		ST_DIV_LEFT,
		ST_DIV_RIGHT,
		ST_DIV_ALL,
		ST_EMIT
	} state_t;

	// atan(2^-i) in degrees with TAB_FRAC fraction bits.
	function automatic z_t atan_tab(input logic [STEP_W-1:0] idx);
		z_t v;
		case (idx)
			5'd0:  v = 34'sd754974720;
			5'd1:  v = 34'sd445687602;
			5'd2:  v = 34'sd235489088;
			5'd3:  v = 34'sd119537938;
			5'd4:  v = 34'sd60000934;
			5'd5:  v = 34'sd30029717;
			5'd6:  v = 34'sd15018523;
			5'd7:  v = 34'sd7509720;
			5'd8:  v = 34'sd3754917;
			5'd9:  v = 34'sd1877466;
			5'd10: v = 34'sd938734;
			5'd11: v = 34'sd469367;
			5'd12: v = 34'sd234684;
			5'd13: v = 34'sd117342;
			5'd14: v = 34'sd58671;
			5'd15: v = 34'sd29335;
			5'd16: v = 34'sd14668;
			5'd17: v = 34'sd7334;
			5'd18: v = 34'sd3667;
			5'd19: v = 34'sd1833;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

@@ hw/rtl/saa_if.sv @@
// Valid/ready channels of the segment angle side averager.
// One interface for segment requests and one for result requests;
// payload types come from saa_pkg.
`timescale 1ns / 1ps

interface saa_seg_if;
	logic          valid;
	logic          ready;
	saa_pkg::seg_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface saa_res_if;
	logic          valid;
	logic          ready;
	saa_pkg::res_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/segment_angle_side_averager_top.sv @@
// Top level of the segment angle side averager: controller, side
// accumulators, configuration registers and result register.
// Depends on saa_pkg, saa_if, saa_cordic and saa_div.
//
//  channel   dir  handshake      payload
//  seg       in   valid/ready    saa_pkg::seg_t (endpoints, last_segment)
//  res       out  valid/ready    saa_pkg::res_t (three angles, two kept counts)
//  cfg_*     in   cfg_we only    cfg_index selects the register, cfg_data the value
//
// A new segment request is taken only once the arctangent unit is done with the
// last one; a vertical or horizontal segment skips its shift-add steps. The last
// segment of a set adds three 18-bit divisions, run one after another on the
// serial divider, one quotient bit per cycle. arst_n clears the controller, the
// sums and counts and restores the register defaults. A result request waits in
// its register while the next set streams in; only the next emit waits for it.
`timescale 1ns / 1ps

module segment_angle_side_averager_top #(
	parameter int ANGLE_FRAC_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [saa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [saa_pkg::CFG_W-1:0]     cfg_data,
	saa_seg_if.sink                       seg,
	saa_res_if.source                     res
);

	localparam int F      = ANGLE_FRAC_BITS;
	localparam int DEG_W  = 8 + F;
	localparam int LSUM_W = 17 + F;
	localparam int RSUM_W = 18 + F;
	localparam int TW     = saa_pkg::TALLY_W;
	localparam int WW     = saa_pkg::WHOLE_W;
	localparam int DN     = saa_pkg::DIV_N;
	localparam int DD     = saa_pkg::DIV_D;

	localparam logic [DEG_W-1:0] DEG90 = DEG_W'(90) << F;
	localparam logic [DN-1:0] LMAX = DN'(saa_pkg::LEFT_ANGLE_MAX);
	localparam logic [DN-1:0] SMAX = DN'(saa_pkg::SIDE_ANGLE_MAX);

	saa_pkg::state_t state_q, state_d;

	logic [saa_pkg::CFG_W-1:0] left_lim_q, right_lim_q, min_lines_q;

	logic [LSUM_W-1:0] lsum_q;
	logic [RSUM_W-1:0] rsum_q;
	logic [WW-1:0]     whole_q;
	logic [TW-1:0]     ltally_q, rtally_q;

	logic [saa_pkg::X_W-1:0] sx_q;
	logic                    last_q;

	logic          ldrop_q, rdrop_q;
	logic [TW-1:0] lkept_q, rkept_q;
	logic [WW-1:0] whole_adj_q;
	logic [6:0]    la_q;
	logic [7:0]    ra_q, oa_q;

	logic          res_valid_q;
	saa_pkg::res_t res_data_q;

	// Controller outputs.
	logic          cord_start, div_start, emit_load, accum_en, settle_en;
	logic [DN-1:0] div_dividend;
	logic [DD-1:0] div_divisor;

	logic              cord_done;
	logic [DEG_W-1:0]  cord_deg;
	logic              div_done;
	logic [DN-1:0]     div_quo;

	logic signed [11:0] dx;
	logic signed [10:0] dy;

	logic [DEG_W-1:0]  deg_r;
	logic [7:0]        deg_whole;
	logic              is_left, is_right;
	logic [LSUM_W:0]   lsum_add;
	logic [RSUM_W:0]   rsum_add;
	logic [WW:0]       whole_add;
	logic [WW-1:0]     whole_sat;
	logic [16:0]       lsum_int;
	logic [17:0]       rsum_int;
	logic              ldrop, rdrop;
	logic [WW-1:0]     sub;
	logic [WW-1:0]     whole_adj;
	logic [DD-1:0]     kept_sum;
	logic              slot_free;

	assign dx = $signed({1'b0, seg.payload.end_x}) - $signed({1'b0, seg.payload.start_x});
	assign dy = $signed({1'b0, seg.payload.end_y}) - $signed({1'b0, seg.payload.start_y});

	saa_cordic #(
		.ANGLE_FRAC_BITS(F)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cord_start),
		.dx    (dx),
		.dy    (dy),
		.done  (cord_done),
		.deg   (cord_deg)
	);

	saa_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.done    (div_done),
		.quotient(div_quo)
	);

	// Remap, classify and saturating accumulation of one segment.
	always_comb begin
		deg_r     = (cord_deg > DEG90) ? cord_deg - DEG90 : cord_deg + DEG90;
		deg_whole = deg_r[DEG_W-1:F];
		is_left   = (deg_r <= DEG90) && (sx_q <= left_lim_q);
		is_right  = (deg_r > DEG90) && (sx_q >= right_lim_q);
		lsum_add  = {1'b0, lsum_q} + (LSUM_W+1)'(deg_r);
		rsum_add  = {1'b0, rsum_q} + (RSUM_W+1)'(deg_r);
		whole_add = {1'b0, whole_q} + (WW+1)'(deg_whole);
		whole_sat = whole_add[WW] ? '1 : whole_add[WW-1:0];
	end

	// Side drop check; the right side is tested only when the left one stays.
	always_comb begin
		lsum_int  = lsum_q[LSUM_W-1:F];
		rsum_int  = rsum_q[RSUM_W-1:F];
		ldrop     = ltally_q < min_lines_q;
		rdrop     = !ldrop && (rtally_q < min_lines_q);
		sub       = ldrop ? WW'(lsum_int) : WW'(rsum_int);
		if (ldrop || rdrop) begin
			whole_adj = (whole_q > sub) ? whole_q - sub : '0;
		end else begin
			whole_adj = whole_q;
		end
		kept_sum  = DD'(lkept_q) + DD'(rkept_q);
		slot_free = !res_valid_q || res.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= saa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		seg.ready    = 1'b0;
		cord_start   = 1'b0;
		div_start    = 1'b0;
		emit_load    = 1'b0;
		accum_en     = 1'b0;
		settle_en    = 1'b0;
		div_dividend = DN'(lsum_int);
		div_divisor  = DD'(ltally_q);
		case (state_q)
			saa_pkg::ST_IDLE: begin
				seg.ready  = 1'b1;
				cord_start = seg.valid;
				if (seg.valid) begin
					state_d = saa_pkg::ST_ANGLE;
				end
			end
			saa_pkg::ST_ANGLE: begin
				if (cord_done) begin
					accum_en = 1'b1;
					state_d  = last_q ? saa_pkg::ST_SETTLE : saa_pkg::ST_IDLE;
				end
			end
			saa_pkg::ST_SETTLE: begin
				settle_en = 1'b1;
				div_start = 1'b1;
				state_d   = saa_pkg::ST_DIV_LEFT;
			end
			saa_pkg::ST_DIV_LEFT: begin
				div_dividend = DN'(rsum_int);
				div_divisor  = DD'(rtally_q);
				if (div_done) begin
					div_start = 1'b1;
					state_d   = saa_pkg::ST_DIV_RIGHT;
				end
			end
			saa_pkg::ST_DIV_RIGHT: begin
				div_dividend = DN'(whole_adj_q);
				div_divisor  = kept_sum;
				if (div_done) begin
					div_start = 1'b1;
					state_d   = saa_pkg::ST_DIV_ALL;
				end
			end
			saa_pkg::ST_DIV_ALL: begin
				if (div_done) begin
					state_d = saa_pkg::ST_EMIT;
				end
			end
			saa_pkg::ST_EMIT: begin
				if (slot_free) begin
					emit_load = 1'b1;
					state_d   = saa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = saa_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_lim_q  <= saa_pkg::LEFT_X_LIMIT_RST;
			right_lim_q <= saa_pkg::RIGHT_X_LIMIT_RST;
			min_lines_q <= saa_pkg::MIN_SIDE_LINES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				saa_pkg::REG_LEFT_X_LIMIT:   left_lim_q  <= cfg_data;
				saa_pkg::REG_RIGHT_X_LIMIT:  right_lim_q <= cfg_data;
				saa_pkg::REG_MIN_SIDE_LINES: min_lines_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lsum_q      <= '0;
			rsum_q      <= '0;
			whole_q     <= '0;
			ltally_q    <= '0;
			rtally_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (emit_load) begin
				lsum_q   <= '0;
				rsum_q   <= '0;
				whole_q  <= '0;
				ltally_q <= '0;
				rtally_q <= '0;
			end else if (accum_en && is_left) begin
				lsum_q   <= lsum_add[LSUM_W] ? '1 : lsum_add[LSUM_W-1:0];
				ltally_q <= (ltally_q == '1) ? ltally_q : ltally_q + 1'b1;
				whole_q  <= whole_sat;
			end else if (accum_en && is_right) begin
				rsum_q   <= rsum_add[RSUM_W] ? '1 : rsum_add[RSUM_W-1:0];
				rtally_q <= (rtally_q == '1) ? rtally_q : rtally_q + 1'b1;
				whole_q  <= whole_sat;
			end
			if (emit_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cord_start) begin
			sx_q   <= seg.payload.start_x;
			last_q <= seg.payload.last_segment;
		end
		if (settle_en) begin
			ldrop_q     <= ldrop;
			rdrop_q     <= rdrop;
			lkept_q     <= ldrop ? '0 : ltally_q;
			rkept_q     <= rdrop ? '0 : rtally_q;
			whole_adj_q <= whole_adj;
		end
		if (state_q == saa_pkg::ST_DIV_LEFT && div_done) begin
			if (ldrop_q || ltally_q == '0) begin
				la_q <= '0;
			end else begin
				la_q <= (div_quo > LMAX) ? 7'(LMAX) : 7'(div_quo);
			end
		end
		if (state_q == saa_pkg::ST_DIV_RIGHT && div_done) begin
			if (rdrop_q || rtally_q == '0) begin
				ra_q <= '0;
			end else begin
				ra_q <= (div_quo > SMAX) ? 8'(SMAX) : 8'(div_quo);
			end
		end
		if (state_q == saa_pkg::ST_DIV_ALL && div_done) begin
			if (kept_sum == '0) begin
				oa_q <= '0;
			end else begin
				oa_q <= (div_quo > SMAX) ? 8'(SMAX) : 8'(div_quo);
			end
		end
		if (emit_load) begin
			res_data_q.overall_angle <= oa_q;
			res_data_q.left_angle    <= la_q;
			res_data_q.right_angle   <= ra_q;
			res_data_q.left_kept     <= lkept_q;
			res_data_q.right_kept    <= rkept_q;
		end
	end

	assign res.valid   = res_valid_q;
	assign res.payload = res_data_q;

	// A new result request only ever comes out of the emit state.
	a_res_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> $past(state_q) == saa_pkg::ST_EMIT)
		else $error("result request raised outside the emit state");

	a_cord_done_in_angle: assert property (@(posedge clk) disable iff (!arst_n)
		cord_done |-> state_q == saa_pkg::ST_ANGLE)
		else $error("arctangent finished while the controller was not waiting");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == saa_pkg::ST_DIV_LEFT || state_q == saa_pkg::ST_DIV_RIGHT
			|| state_q == saa_pkg::ST_DIV_ALL))
		else $error("divider finished outside a division state");

	// Every emitted set leaves the accumulators empty for the next one.
	a_cleared_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		emit_load |=> (ltally_q == '0 && rtally_q == '0 && whole_q == '0
			&& lsum_q == '0 && rsum_q == '0))
		else $error("side accumulators not cleared after a result");

endmodule

@@ hw/rtl/saa_cordic.sv @@
// Iterative vectoring arctangent: |atan2(dx, dy)| in fixed-point degrees.
// One shift-add step per cycle for saa_pkg::CORDIC_STEPS steps, then a clamp.
// Depends on saa_pkg for the step table and internal widths.
`timescale 1ns / 1ps

module saa_cordic #(
	parameter int ANGLE_FRAC_BITS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic signed [11:0]             dx,
	input  logic signed [10:0]             dy,
	output logic                           done,
	output logic [8+ANGLE_FRAC_BITS-1:0]   deg
);

	localparam int DEG_W = 8 + ANGLE_FRAC_BITS;
	localparam int CW    = saa_pkg::CORD_W;
	localparam int ZW    = saa_pkg::Z_W;
	localparam int SW    = saa_pkg::STEP_W;
	localparam int TF    = saa_pkg::TAB_FRAC;

	localparam logic [SW-1:0] LAST_STEP = SW'(saa_pkg::CORDIC_STEPS - 1);
	localparam logic signed [ZW-1:0] Z90  = ZW'(90) <<< TF;
	localparam logic signed [ZW-1:0] Z180 = ZW'(180) <<< TF;
	localparam logic [DEG_W-1:0] DEG90  = DEG_W'(90) << ANGLE_FRAC_BITS;
	localparam logic [DEG_W-1:0] DEG180 = DEG_W'(180) << ANGLE_FRAC_BITS;

	logic signed [CW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic [SW-1:0]        step_q;
	logic                 busy_q, fin_q, done_q;
	logic [DEG_W-1:0]     deg_q;

	logic signed [11:0]   ax;
	logic signed [11:0]   ndy;
	logic                 exact;
	logic signed [CW-1:0] x_init, y_init;
	logic signed [CW-1:0] sx, sy;
	logic signed [ZW-1:0] tab;
	logic [ZW-1:0]        z_clamped;
	logic [DEG_W-1:0]     deg_fin;

	always_comb begin
		ax     = (dx < 0) ? -dx : dx;
		ndy    = -12'(dy);
		exact  = (dx == '0) || (dy == '0);
		if (dy > 0) begin
			x_init = CW'(dy) <<< saa_pkg::PRE_SCALE;
			y_init = CW'(ax) <<< saa_pkg::PRE_SCALE;
		end else begin
			x_init = CW'(ax) <<< saa_pkg::PRE_SCALE;
			y_init = CW'(ndy) <<< saa_pkg::PRE_SCALE;
		end
		sx  = x_q >>> step_q;
		sy  = y_q >>> step_q;
		tab = saa_pkg::atan_tab(step_q);
		if (z_q < 0) begin
			z_clamped = '0;
		end else if (z_q > Z180) begin
			z_clamped = Z180;
		end else begin
			z_clamped = z_q;
		end
		deg_fin = DEG_W'(z_clamped >> (TF - ANGLE_FRAC_BITS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= !exact;
			fin_q  <= 1'b0;
			done_q <= exact;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == LAST_STEP) begin
				busy_q <= 1'b0;
				fin_q  <= 1'b1;
			end
		end else if (fin_q) begin
			fin_q  <= 1'b0;
			done_q <= 1'b1;
		end else begin
			done_q <= 1'b0;
		end
	end

	// Both updates of a step read the old x and y.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x_init;
			y_q <= y_init;
			z_q <= (dy > 0) ? '0 : Z90;
			if (dx == '0) begin
				deg_q <= (dy < 0) ? DEG180 : '0;
			end else begin
				deg_q <= DEG90;
			end
		end else if (busy_q) begin
			if (y_q > 0) begin
				x_q <= x_q + sy;
				y_q <= y_q - sx;
				z_q <= z_q + tab;
			end else if (y_q < 0) begin
				x_q <= x_q - sy;
				y_q <= y_q + sx;
				z_q <= z_q - tab;
			end
		end else if (fin_q) begin
			deg_q <= deg_fin;
		end
	end

	assign done = done_q;
	assign deg  = deg_q;

endmodule

@@ hw/rtl/saa_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
// Shared by the left, right and overall averages of the averager.
// Depends on saa_pkg for its widths.
`timescale 1ns / 1ps

module saa_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [saa_pkg::DIV_N-1:0] dividend,
	input  logic [saa_pkg::DIV_D-1:0] divisor,
	output logic                      done,
	output logic [saa_pkg::DIV_N-1:0] quotient
);

	localparam int N  = saa_pkg::DIV_N;
	localparam int D  = saa_pkg::DIV_D;
	localparam int CW = saa_pkg::DIV_CNT_W;
	localparam logic [CW-1:0] LAST = CW'(N - 1);

	logic [N-1:0]  quo_q;
	logic [D-1:0]  rem_q;
	logic [D-1:0]  dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;

	logic [D:0]    shifted;
	logic          ge;
	logic [D:0]    diff;
	logic [D-1:0]  rem_next;

	always_comb begin
		shifted  = {rem_q, quo_q[N-1]};
		ge       = shifted >= {1'b0, dvs_q};
		diff     = shifted - {1'b0, dvs_q};
		rem_next = ge ? diff[D-1:0] : shifted[D-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[N-2:0], ge};
			rem_q <= rem_next;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
